[rtl/warmup_moving_average_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the warm-up moving average
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WARMUP_MOVING_AVERAGE_ASSERT_SVH
`define WARMUP_MOVING_AVERAGE_ASSERT_SVH

// same-cycle implication
`define WMA_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("warmup_moving_average: assertion failed");

// next-cycle implication
`define WMA_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("warmup_moving_average: assertion failed");

`endif

[rtl/wma_pkg.sv]
// ----------------------------------------------------------------------------
// wma_pkg
// Shared constants of the warm-up moving average.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int DEF_MAX_WINDOW  = 128;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int CFG_BITS        = 8;

    localparam logic [CFG_BITS-1:0] WINDOW_RESET = 8'd7;

endpackage

[rtl/wma_ram.sv]
// ----------------------------------------------------------------------------
// wma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wma_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/warmup_moving_average.sv]
// ----------------------------------------------------------------------------
// warmup_moving_average
// Moving average of unsigned fixed-point samples with a warm-up phase.
//
// Input channel: in_valid / in_stall with sample and last_sample. The block
// raises in_stall while busy or while cfg_valid is high; one item is in flight.
// Output channel: out_valid / out_stall with average, series_end, too_short,
// held in an output register until taken.
// Configuration: cfg_valid / cfg_ready with cfg_data (window_size); a write
// also starts a new series. cfg_ready is high while the block is idle.
// SB = SAMPLE_BITS + clog2(MAX_WINDOW + 1) (32 at the defaults).
// An item passes through the history read, the sum update, SB steps of the
// bit-serial restoring divider that forms sum / count one quotient bit per
// cycle, and the load of the output register.
// A stalled receiver holds the result; a finished quotient waits in the
// divider until the output register is free, and no new item is taken then.
// Reset restores window_size 7 and an empty series; history needs no clear.
// ----------------------------------------------------------------------------
module warmup_moving_average #(
    parameter int MAX_WINDOW  = wma_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = wma_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [wma_pkg::CFG_BITS-1:0] cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [SAMPLE_BITS-1:0]       sample,
    input  logic                         last_sample,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [SAMPLE_BITS-1:0]       average,
    output logic                         series_end,
    output logic                         too_short
);

    import wma_pkg::*;

    localparam int AW    = $clog2(MAX_WINDOW);
    localparam int CW    = $clog2(MAX_WINDOW + 1);
    localparam int SW    = SAMPLE_BITS + CW;
    localparam int CNTW  = $clog2(SW + 1);
    localparam int WBITS = (CW > CFG_BITS) ? CW : CFG_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [CFG_BITS-1:0]    window_reg, window_next;
    logic [SW-1:0]          sum_reg, sum_next;
    logic [CW-1:0]          seen_reg, seen_next;
    logic [AW-1:0]          wslot_reg, wslot_next;
    logic [AW-1:0]          slot_reg, slot_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic                   last_reg, last_next;
    logic                   short_reg, short_next;
    logic [SW-1:0]          dq_reg, dq_next;
    logic [CW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          divisor_reg, divisor_next;
    logic [CNTW-1:0]        cnt_reg, cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] average_reg, average_next;
    logic                   series_end_reg, series_end_next;
    logic                   too_short_reg, too_short_next;

    logic [WBITS-1:0]       ws_ext;
    logic [WBITS-1:0]       eff_ext;
    logic [CW-1:0]          w_eff;
    logic [AW-1:0]          slot_start;
    logic [CW-1:0]          slot_inc;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   ram_we;
    logic                   full;
    logic [CW:0]            trial;
    logic                   ge;
    logic [CW:0]            trial_diff;
    logic                   accept;
    logic                   out_free;

    assign ws_ext  = WBITS'(window_reg);
    assign eff_ext = (ws_ext == '0) ? WBITS'(1) :
                     ((ws_ext > WBITS'(MAX_WINDOW)) ? WBITS'(MAX_WINDOW) : ws_ext);
    assign w_eff   = eff_ext[CW-1:0];

    assign slot_start = (CW'(wslot_reg) >= w_eff) ? '0 : wslot_reg;
    assign slot_inc   = CW'(slot_reg) + CW'(1);
    assign full       = (seen_reg >= w_eff);

    assign trial      = {rem_reg, dq_reg[SW-1]};
    assign ge         = (trial >= {1'b0, divisor_reg});
    assign trial_diff = trial - {1'b0, divisor_reg};

    assign in_stall  = (state_reg != ST_IDLE) || cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_we    = (state_reg == ST_READ);

    wma_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_start),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        window_next     = window_reg;
        sum_next        = sum_reg;
        seen_next       = seen_reg;
        wslot_next      = wslot_reg;
        slot_next       = slot_reg;
        sample_next     = sample_reg;
        last_next       = last_reg;
        short_next      = short_reg;
        dq_next         = dq_reg;
        rem_next        = rem_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg;
        average_next    = average_reg;
        series_end_next = series_end_reg;
        too_short_next  = too_short_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    window_next = cfg_data;
                    sum_next    = '0;
                    seen_next   = '0;
                    wslot_next  = '0;
                end
                else if (accept)
                begin
                    sample_next = sample;
                    last_next   = last_sample;
                    slot_next   = slot_start;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                // drop the oldest sample once the window is full
                if (full)
                begin
                    sum_next    = sum_reg - SW'(ram_rdata) + SW'(sample_reg);
                    divisor_next = seen_reg;
                    short_next  = 1'b0;
                end
                else
                begin
                    sum_next     = sum_reg + SW'(sample_reg);
                    seen_next    = seen_reg + CW'(1);
                    divisor_next = seen_reg + CW'(1);
                    short_next   = ((seen_reg + CW'(1)) < w_eff);
                end
                dq_next  = sum_next;
                rem_next = '0;
                cnt_next = CNTW'(SW);
                wslot_next = (slot_inc >= w_eff) ? '0 : slot_inc[AW-1:0];
                if (last_reg)
                begin
                    sum_next   = '0;
                    seen_next  = '0;
                    wslot_next = '0;
                end
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_reg != '0)
                begin
                    rem_next = ge ? trial_diff[CW-1:0] : trial[CW-1:0];
                    dq_next  = {dq_reg[SW-2:0], ge};
                    cnt_next = cnt_reg - CNTW'(1);
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    average_next    = dq_reg[SAMPLE_BITS-1:0];
                    series_end_next = last_reg;
                    too_short_next  = last_reg && short_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            window_reg    <= WINDOW_RESET;
            sum_reg       <= '0;
            seen_reg      <= '0;
            wslot_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            window_reg    <= window_next;
            sum_reg       <= sum_next;
            seen_reg      <= seen_next;
            wslot_reg     <= wslot_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg       <= slot_next;
        sample_reg     <= sample_next;
        last_reg       <= last_next;
        short_reg      <= short_next;
        dq_reg         <= dq_next;
        rem_reg        <= rem_next;
        divisor_reg    <= divisor_next;
        average_reg    <= average_next;
        series_end_reg <= series_end_next;
        too_short_reg  <= too_short_next;
    end

    assign out_valid  = out_valid_reg;
    assign average    = average_reg;
    assign series_end = series_end_reg;
    assign too_short  = too_short_reg;

`include "warmup_moving_average_assert.svh"

    `WMA_ASSERT_NEXT(a_accept_reads, accept && !cfg_valid, state_reg == ST_READ)
    `WMA_ASSERT_NOW(a_seen_in_window, 1'b1, seen_reg <= w_eff)
    `WMA_ASSERT_NOW(a_slot_in_window, 1'b1, CW'(wslot_reg) < w_eff)
    `WMA_ASSERT_NOW(a_divisor_nonzero, state_reg == ST_DIV, divisor_reg != '0)
    `WMA_ASSERT_NOW(a_result_from_div, $rose(out_valid_reg), $past(state_reg) == ST_DIV)

endmodule
